[hdl/pdf_token_boundary_scanner_macros.svh]
// Assertion macros shared by the scanner modules.
`ifndef PDF_TOKEN_BOUNDARY_SCANNER_MACROS_SVH
`define PDF_TOKEN_BOUNDARY_SCANNER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/ptbs_pkg.sv]
package ptbs_pkg;

	typedef enum logic [3:0] {
		M_IDLE       = 4'd0,
		M_WS         = 4'd1,
		M_COMMENT    = 4'd2,
		M_COMMENT_CR = 4'd3,
		M_LITERAL    = 4'd4,
		M_HEX        = 4'd5,
		M_LT         = 4'd6,
		M_GT         = 4'd7,
		M_NAME       = 4'd8,
		M_NUMBER     = 4'd9,
		M_KEYWORD    = 4'd10
	} scan_mode_t;

	typedef enum logic [1:0] {
		P_INT  = 2'd0,
		P_FRAC = 2'd1,
		P_EXP0 = 2'd2,
		P_EXP1 = 2'd3
	} num_phase_t;

	typedef enum logic [3:0] {
		K_WS         = 4'd0,
		K_COMMENT    = 4'd1,
		K_LITERAL    = 4'd2,
		K_HEX        = 4'd3,
		K_DICTOPEN   = 4'd4,
		K_DICTCLOSE  = 4'd5,
		K_ARRAYOPEN  = 4'd6,
		K_ARRAYCLOSE = 4'd7,
		K_NAME       = 4'd8,
		K_NUMBER     = 4'd9,
		K_KEYWORD    = 4'd10
	} token_kind_t;

	// One token descriptor, offsets and lengths already cut to the port width.
	typedef struct packed {
		token_kind_t kind;
		logic [31:0] offset;
		logic [31:0] length;
		logic        ovf;
	} ptbs_res_t;

	// Everything one byte produces: one or two descriptors.
	typedef struct packed {
		logic      two;
		logic      fin;
		ptbs_res_t first;
		ptbs_res_t second;
	} ptbs_rec_t;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = 2;
	localparam int unsigned QCW    = 3;

endpackage

[hdl/ptbs_byte_if.sv]
interface ptbs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

[hdl/ptbs_token_if.sv]
interface ptbs_token_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [31:0] token_offset;
	logic [31:0] token_length;
	logic        depth_overflow;
	logic        stream_done;
	logic        last_of_run;

	modport source (output valid, output token_kind, output token_offset,
		output token_length, output depth_overflow, output stream_done,
		output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_offset,
		input token_length, input depth_overflow, input stream_done,
		input last_of_run, output ready);
endinterface

[hdl/ptbs_front.sv]
module ptbs_front
	import ptbs_pkg::*;
#(
	parameter int unsigned POSITION_BITS = 32,
	parameter int unsigned DEPTH_MAX     = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	ptbs_byte_if.sink   bytes,
	input  logic        full,
	output logic        push,
	output ptbs_rec_t   push_rec
);

	localparam int unsigned PB = POSITION_BITS;
	localparam int unsigned DB = $clog2(DEPTH_MAX + 1);
	localparam logic [DB-1:0] DMAX = DB'(DEPTH_MAX);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_LBRC  = 8'h7B;
	localparam logic [7:0] CH_RBRC  = 8'h7D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_E_UC  = 8'h45;
	localparam logic [7:0] CH_E_LC  = 8'h65;

	function automatic logic is_ws(input logic [7:0] c);
		return c == CH_NUL || c == CH_TAB || c == CH_LF || c == CH_FF ||
			c == CH_CR || c == CH_SP;
	endfunction

	function automatic logic is_delim(input logic [7:0] c);
		return c == CH_LPAR || c == CH_RPAR || c == CH_LT || c == CH_GT ||
			c == CH_LBRK || c == CH_RBRK || c == CH_LBRC || c == CH_RBRC ||
			c == CH_SLASH || c == CH_PCT;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [31:0] to32(input logic [PB-1:0] x);
		logic [PB+31:0] w;
		w = {32'b0, x};
		return w[31:0];
	endfunction

	function automatic ptbs_res_t mk(input token_kind_t k, input logic [31:0] off,
		input logic [31:0] len, input logic ov);
		ptbs_res_t r;
		r.kind   = k;
		r.offset = off;
		r.length = len;
		r.ovf    = ov;
		return r;
	endfunction

	scan_mode_t  mode_q, mode_v, mode_n;
	num_phase_t  phase_q, phase_n;
	logic [DB-1:0] depth_q, depth_n, depth_dec;
	logic        esc_q, esc_n, ovf_q, ovf_n;
	logic [PB-1:0] begin_q, begin_n, pos_q, pos_n;
	logic [PB-1:0] len_excl, len_incl;

	logic [7:0]  b;
	logic        fin, accept, taken, num_ok, is_e;
	logic        close_v, open_v;
	ptbs_res_t   close_r, open_r;
	token_kind_t fl_kind;
	logic        fl_ovf;

	assign b        = bytes.data_byte;
	assign fin      = bytes.final_byte;
	assign bytes.ready = !full;
	assign accept   = bytes.valid && !full;
	assign len_excl = pos_q - begin_q;
	assign len_incl = len_excl + PB'(1);
	assign depth_dec = (depth_q != '0) ? depth_q - DB'(1) : '0;
	assign is_e     = b == CH_E_UC || b == CH_E_LC;

	always_comb begin
		mode_n  = mode_q;
		phase_n = phase_q;
		depth_n = depth_q;
		esc_n   = esc_q;
		ovf_n   = ovf_q;
		begin_n = begin_q;
		pos_n   = pos_q + PB'(1);
		close_v = 1'b0;
		close_r = '0;
		open_v  = 1'b0;
		open_r  = '0;
		taken   = 1'b1;
		num_ok  = 1'b0;
		fl_kind = K_WS;
		fl_ovf  = 1'b0;

		// A pending '<' either becomes a dictionary open or turns into a hex string.
		mode_v = mode_q;
		if (mode_q == M_LT) begin
			if (b == CH_LT) begin
				close_v = 1'b1;
				close_r = mk(K_DICTOPEN, to32(begin_q), to32(len_incl), 1'b0);
				mode_v  = M_IDLE;
			end else begin
				mode_v = M_HEX;
			end
		end
		mode_n = mode_v;

		unique case (mode_v)
			M_WS: begin
				if (!is_ws(b)) begin
					close_v = 1'b1;
					close_r = mk(K_WS, to32(begin_q), to32(len_excl), 1'b0);
					mode_n  = M_IDLE;
					taken   = 1'b0;
				end
			end
			M_COMMENT: begin
				if (b == CH_CR) begin
					mode_n = M_COMMENT_CR;
				end else if (b == CH_LF) begin
					close_v = 1'b1;
					close_r = mk(K_COMMENT, to32(begin_q), to32(len_incl), 1'b0);
					mode_n  = M_IDLE;
				end
			end
			M_COMMENT_CR: begin
				close_v = 1'b1;
				mode_n  = M_IDLE;
				if (b == CH_LF) begin
					close_r = mk(K_COMMENT, to32(begin_q), to32(len_incl), 1'b0);
				end else begin
					close_r = mk(K_COMMENT, to32(begin_q), to32(len_excl), 1'b0);
					taken   = 1'b0;
				end
			end
			M_LITERAL: begin
				if (esc_q) begin
					esc_n = 1'b0;
				end else if (b == CH_BSL) begin
					esc_n = 1'b1;
				end else if (b == CH_LPAR) begin
					if (depth_q >= DMAX) begin
						depth_n = DMAX;
						ovf_n   = 1'b1;
					end else begin
						depth_n = depth_q + DB'(1);
					end
				end else if (b == CH_RPAR) begin
					depth_n = depth_dec;
					if (depth_dec == '0) begin
						close_v = 1'b1;
						close_r = mk(K_LITERAL, to32(begin_q), to32(len_incl), ovf_q);
						mode_n  = M_IDLE;
					end
				end
			end
			M_HEX: begin
				if (b == CH_GT) begin
					close_v = 1'b1;
					close_r = mk(K_HEX, to32(begin_q), to32(len_incl), 1'b0);
					mode_n  = M_IDLE;
				end else if (!is_ws(b) && !is_hex(b)) begin
					close_v = 1'b1;
					close_r = mk(K_HEX, to32(begin_q), to32(len_excl), 1'b0);
					mode_n  = M_IDLE;
					taken   = 1'b0;
				end
			end
			M_GT: begin
				close_v = 1'b1;
				mode_n  = M_IDLE;
				if (b == CH_GT) begin
					close_r = mk(K_DICTCLOSE, to32(begin_q), to32(len_incl), 1'b0);
				end else begin
					close_r = mk(K_ARRAYCLOSE, to32(begin_q), to32(len_excl), 1'b0);
					taken   = 1'b0;
				end
			end
			M_NAME, M_KEYWORD: begin
				if (is_ws(b) || is_delim(b)) begin
					close_v = 1'b1;
					close_r = mk((mode_v == M_NAME) ? K_NAME : K_KEYWORD, to32(begin_q),
						to32(len_excl), 1'b0);
					mode_n  = M_IDLE;
					taken   = 1'b0;
				end
			end
			M_NUMBER: begin
				unique case (phase_q)
					P_INT: begin
						if (is_digit(b)) begin
							num_ok = 1'b1;
						end else if (b == CH_DOT) begin
							num_ok  = 1'b1;
							phase_n = P_FRAC;
						end else if (is_e) begin
							num_ok  = 1'b1;
							phase_n = P_EXP0;
						end
					end
					P_FRAC: begin
						if (is_digit(b)) begin
							num_ok = 1'b1;
						end else if (is_e) begin
							num_ok  = 1'b1;
							phase_n = P_EXP0;
						end
					end
					P_EXP0: begin
						if (is_digit(b) || b == CH_PLUS || b == CH_MINUS) begin
							num_ok  = 1'b1;
							phase_n = P_EXP1;
						end
					end
					P_EXP1: begin
						num_ok = is_digit(b);
					end
				endcase
				if (!num_ok) begin
					close_v = 1'b1;
					close_r = mk(K_NUMBER, to32(begin_q), to32(len_excl), 1'b0);
					mode_n  = M_IDLE;
					taken   = 1'b0;
				end
			end
			M_IDLE: begin
				if (!close_v) begin
					taken = 1'b0;
				end
			end
			M_LT: begin
				// Resolved above, never seen here.
				mode_n = M_HEX;
			end
		endcase

		// The byte was not absorbed by an open token, so it starts a new one.
		if (!taken) begin
			begin_n = pos_q;
			esc_n   = 1'b0;
			ovf_n   = 1'b0;
			depth_n = '0;
			phase_n = P_INT;
			mode_n  = M_IDLE;
			priority if (is_ws(b)) begin
				mode_n = M_WS;
			end else if (b == CH_PCT) begin
				mode_n = M_COMMENT;
			end else if (b == CH_LPAR) begin
				mode_n  = M_LITERAL;
				depth_n = DB'(1);
			end else if (b == CH_LT) begin
				mode_n = M_LT;
			end else if (b == CH_GT) begin
				mode_n = M_GT;
			end else if (b == CH_LBRK) begin
				open_v = 1'b1;
				open_r = mk(K_ARRAYOPEN, to32(pos_q), 32'd1, 1'b0);
			end else if (b == CH_RBRK) begin
				open_v = 1'b1;
				open_r = mk(K_ARRAYCLOSE, to32(pos_q), 32'd1, 1'b0);
			end else if (b == CH_SLASH) begin
				mode_n = M_NAME;
			end else if (b == CH_PLUS || b == CH_MINUS || is_digit(b)) begin
				mode_n = M_NUMBER;
			end else if (b == CH_DOT) begin
				mode_n  = M_NUMBER;
				phase_n = P_FRAC;
			end else if (is_delim(b)) begin
				open_v = 1'b1;
				open_r = mk(K_KEYWORD, to32(pos_q), 32'd1, 1'b0);
			end else begin
				mode_n = M_KEYWORD;
			end
		end

		// The last byte flushes whatever token is still open and restarts the stream.
		if (fin) begin
			unique case (mode_n)
				M_WS:                    fl_kind = K_WS;
				M_COMMENT, M_COMMENT_CR: fl_kind = K_COMMENT;
				M_LITERAL: begin
					fl_kind = K_LITERAL;
					fl_ovf  = ovf_n;
				end
				M_LT, M_HEX:             fl_kind = K_HEX;
				M_GT:                    fl_kind = K_ARRAYCLOSE;
				M_NAME:                  fl_kind = K_NAME;
				M_NUMBER:                fl_kind = K_NUMBER;
				M_KEYWORD:               fl_kind = K_KEYWORD;
				M_IDLE:                  fl_kind = K_WS;
			endcase
			if (mode_n != M_IDLE) begin
				open_v = 1'b1;
				open_r = mk(fl_kind, to32(begin_n), taken ? to32(len_incl) : 32'd1, fl_ovf);
			end
			mode_n  = M_IDLE;
			phase_n = P_INT;
			depth_n = '0;
			esc_n   = 1'b0;
			ovf_n   = 1'b0;
			begin_n = '0;
			pos_n   = '0;
		end
	end

	always_comb begin
		push_rec.fin    = fin;
		push_rec.two    = close_v && open_v;
		push_rec.first  = close_v ? close_r : open_r;
		push_rec.second = open_r;
		push            = accept && (close_v || open_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			phase_q <= P_INT;
			depth_q <= '0;
			esc_q   <= 1'b0;
			ovf_q   <= 1'b0;
			begin_q <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			mode_q  <= mode_n;
			phase_q <= phase_n;
			depth_q <= depth_n;
			esc_q   <= esc_n;
			ovf_q   <= ovf_n;
			begin_q <= begin_n;
			pos_q   <= pos_n;
		end
	end

endmodule

[hdl/ptbs_queue.sv]
`include "pdf_token_boundary_scanner_macros.svh"

module ptbs_queue
	import ptbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ptbs_rec_t push_rec,
	input  logic      pop,
	output ptbs_rec_t head,
	output logic      full,
	output logic      empty
);

	ptbs_rec_t       slot_q [QDEPTH];
	logic [QAW-1:0]  wr_q, rd_q;
	logic [QCW-1:0]  cnt_q;

	assign full  = cnt_q == QCW'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QAW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

	`PTBS_ASSERT_NOW(a_no_push_full, clk, arst_n, push, !full, "queue written while full")
	`PTBS_ASSERT_NOW(a_no_pop_empty, clk, arst_n, pop, !empty, "queue read while empty")
	`PTBS_ASSERT_NEXT(a_cnt_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + QCW'(1), "queue fill count did not rise")

endmodule

[hdl/ptbs_back.sv]
`include "pdf_token_boundary_scanner_macros.svh"

module ptbs_back
	import ptbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ptbs_rec_t   head,
	input  logic        empty,
	output logic        pop,
	ptbs_token_if.source tokens
);

	logic      out_valid_q, sub_q;
	ptbs_res_t res_q;
	logic      last_q, done_q;
	logic      load, last_c;
	ptbs_res_t cur;

	// The output register may be refilled when it is empty or its transfer completes.
	assign load   = !out_valid_q || tokens.ready;
	assign last_c = !head.two || sub_q;
	assign cur    = sub_q ? head.second : head.first;
	assign pop    = load && !empty && last_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= 1'b0;
		end else if (load) begin
			if (!empty) begin
				out_valid_q <= 1'b1;
				sub_q       <= !last_c;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			res_q  <= cur;
			last_q <= last_c;
			done_q <= last_c && head.fin;
		end
	end

	assign tokens.valid          = out_valid_q;
	assign tokens.token_kind     = res_q.kind;
	assign tokens.token_offset   = res_q.offset;
	assign tokens.token_length   = res_q.length;
	assign tokens.depth_overflow = res_q.ovf;
	assign tokens.stream_done    = done_q;
	assign tokens.last_of_run    = last_q;

	`PTBS_ASSERT_NOW(a_second_after_first, clk, arst_n, sub_q, out_valid_q && !last_q, "second descriptor pending without the first on show")
	`PTBS_ASSERT_NOW(a_done_is_last, clk, arst_n, out_valid_q && done_q, last_q, "stream end flagged on a descriptor that is not the last of its byte")

endmodule

[hdl/pdf_token_boundary_scanner.sv]
// A taken byte's descriptors are written into a four-entry queue and reach the token port
// through an output register that holds its descriptor while tokens.ready is low. One byte per
// cycle is taken while the queue is not full; a byte that yields two descriptors shows them one
// after the other, and the queue absorbs such bursts. Reset (arst_n low) clears the scanner
// state, the stream position, the queue and the output register at once; there is no clearing pass.
module pdf_token_boundary_scanner
	import ptbs_pkg::*;
#(
	parameter int unsigned POSITION_BITS = 32,
	parameter int unsigned DEPTH_MAX     = 255
) (
	input  logic         clk,
	input  logic         arst_n,
	ptbs_byte_if.sink    bytes,
	ptbs_token_if.source tokens
);

	logic      push, pop, full, empty;
	ptbs_rec_t push_rec, head;

	ptbs_front #(
		.POSITION_BITS (POSITION_BITS),
		.DEPTH_MAX     (DEPTH_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes    (bytes),
		.full     (full),
		.push     (push),
		.push_rec (push_rec)
	);

	ptbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	ptbs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.tokens (tokens)
	);

endmodule
